>>> design/int8_conv_mac_requantize_16ch_unit_defines.svh
// Assertion macros shared by the conv MAC requantize block.
// Expects clk and arst_n in the scope of each use.
`ifndef INT8_CONV_MAC_REQUANTIZE_16CH_UNIT_DEFINES_SVH
`define INT8_CONV_MAC_REQUANTIZE_16CH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ICMRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ICMRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/icmrq_pkg.sv
// Shared types and constants for the int8 conv MAC / requantize block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmrq_pkg;

	// number of physical lanes (output channels carried by a transaction)
	localparam int LANES = 16;
	// s1 (accumulate) then s2..s5 (requantize)
	localparam int NUM_STAGES = 5;
	localparam int ADDR_W = 5;

	// register indexes (byte address bits [4:2])
	typedef enum logic [2:0] {
		REG_SCALE_MULT  = 3'd0,
		REG_SCALE_SHIFT = 3'd1,
		REG_CLAMP_LOW   = 3'd2,
		REG_CLAMP_HIGH  = 3'd3,
		REG_ZERO_POINT  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic               func;
		logic [3:0]         bias_index;
		logic signed [31:0] bias_value;
		logic [7:0]         activation;
		logic [63:0]        weights_low;
		logic [63:0]        weights_high;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [63:0] bytes_low;
		logic [63:0] bytes_high;
	} result_t;

	typedef struct packed {
		logic [31:0]        scale_multiplier;
		logic [5:0]         scale_shift;
		logic signed [31:0] clamp_low;
		logic signed [31:0] clamp_high;
		logic [7:0]         output_zero_point;
	} cfg_t;

	// per-cycle lane control: step[0] is a last-MAC transaction, step[k] loads stage k+1
	typedef struct packed {
		logic                  mac;
		logic [NUM_STAGES-1:0] step;
	} lane_ctl_t;

endpackage

`default_nettype wire

>>> design/icmrq_requant.sv
// Requantization pipeline of one lane: bias add, scale multiply, rounding shift,
// saturation, clamp and zero point. Uses icmrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmrq_requant (
	input  wire logic                                clk,
	input  wire icmrq_pkg::cfg_t                     cfg,
	input  wire logic [icmrq_pkg::NUM_STAGES-2:0]    step,
	input  wire logic [31:0]                         tot,
	input  wire logic [31:0]                         bias,
	output logic [7:0]                               res_byte
);

	logic [31:0]        sum;
	logic [31:0]        mag_s2;
	logic               neg_s2;
	logic [63:0]        prod_s3;
	logic               neg_s3;
	logic [63:0]        q_s4;
	logic               up_s4;
	logic               neg_s4;
	logic signed [31:0] v_s5;
	logic [63:0]        rem_mask;
	logic [63:0]        rem;
	logic [63:0]        half;
	logic [63:0]        q;
	logic               up;
	logic [63:0]        qr;
	logic signed [31:0] v;
	logic signed [31:0] c_hi;
	logic signed [31:0] c_lo;
	logic signed [32:0] z;

	// s2: wrapped bias add, split into sign and magnitude
	assign sum = tot + bias;

	always_ff @(posedge clk) begin
		if (step[0]) begin
			neg_s2 <= sum[31];
			mag_s2 <= sum[31] ? (32'd0 - sum) : sum;
		end
	end

	// s3: unsigned scale multiply, product below 2^63
	always_ff @(posedge clk) begin
		if (step[1]) begin
			prod_s3 <= 64'(mag_s2) * 64'(cfg.scale_multiplier);
			neg_s3  <= neg_s2;
		end
	end

	// s4: shift and round half to even on the magnitude
	assign rem_mask = (64'd1 << cfg.scale_shift) - 64'd1;
	assign rem      = prod_s3 & rem_mask;
	assign half     = 64'd1 << 6'(cfg.scale_shift - 6'd1);
	assign q        = prod_s3 >> cfg.scale_shift;
	assign up       = (cfg.scale_shift != 6'd0) &&
		((rem > half) || ((rem == half) && q[0]));

	always_ff @(posedge clk) begin
		if (step[2]) begin
			q_s4   <= q;
			up_s4  <= up;
			neg_s4 <= neg_s3;
		end
	end

	// s5: restore sign, saturate to int32
	assign qr = q_s4 + 64'(up_s4);

	always_comb begin
		if (neg_s4) begin
			v = (qr > 64'h8000_0000) ? 32'sh8000_0000 : signed'(32'd0 - qr[31:0]);
		end else begin
			v = (qr > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(qr[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (step[3]) begin
			v_s5 <= v;
		end
	end

	// clamp high then low, add zero point, saturate to a byte
	assign c_hi = (v_s5 > cfg.clamp_high) ? cfg.clamp_high : v_s5;
	assign c_lo = (c_hi < cfg.clamp_low) ? cfg.clamp_low : c_hi;
	assign z    = 33'(c_lo) + signed'({25'd0, cfg.output_zero_point});

	always_comb begin
		if (z < 33'sd0) begin
			res_byte = 8'd0;
		end else if (z > 33'sd255) begin
			res_byte = 8'hFF;
		end else begin
			res_byte = z[7:0];
		end
	end

endmodule

`default_nettype wire

>>> design/icmrq_lane.sv
// One output channel: bias word, wrapping MAC accumulator and its requantizer.
// Uses icmrq_pkg and icmrq_requant.
`timescale 1ns / 1ps
`default_nettype none

module icmrq_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire icmrq_pkg::lane_ctl_t ctl,
	input  wire icmrq_pkg::cfg_t      cfg,
	input  wire logic                 bias_we,
	input  wire logic [31:0]          bias_value,
	input  wire logic [7:0]           activation,
	input  wire logic [7:0]           weight,
	output logic [7:0]                res_byte
);

	logic [31:0]        acc_q;
	logic [31:0]        bias_q;
	logic [31:0]        tot_s1;
	logic signed [7:0]  act;
	logic signed [15:0] prod;
	logic [31:0]        acc_sum;

	// activation minus 128 is the byte with its top bit flipped
	assign act     = signed'({~activation[7], activation[6:0]});
	assign prod    = act * signed'(weight);
	assign acc_sum = acc_q + 32'(prod);

	// accumulator, cleared by the last MAC transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.mac) begin
			acc_q <= ctl.step[0] ? '0 : acc_sum;
		end
	end

	// bias word, kept across results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (bias_we) begin
			bias_q <= bias_value;
		end
	end

	// s1: final accumulator value
	always_ff @(posedge clk) begin
		if (ctl.step[0]) begin
			tot_s1 <= acc_sum;
		end
	end

	icmrq_requant u_requant (
		.clk      (clk),
		.cfg      (cfg),
		.step     (ctl.step[icmrq_pkg::NUM_STAGES-1:1]),
		.tot      (tot_s1),
		.bias     (bias_q),
		.res_byte (res_byte)
	);

endmodule

`default_nettype wire

>>> design/icmrq_regs.sv
// APB-style configuration registers for the requantizer.
// Uses icmrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmrq_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [icmrq_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output icmrq_pkg::cfg_t                   cfg
);

	icmrq_pkg::cfg_t       cfg_q;
	icmrq_pkg::reg_idx_t   idx;
	logic                  wr;

	assign pready = 1'b1;
	assign idx    = icmrq_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_multiplier  <= 32'd1;
			cfg_q.scale_shift       <= 6'd0;
			cfg_q.clamp_low         <= 32'sh8000_0000;
			cfg_q.clamp_high        <= 32'sh7FFF_FFFF;
			cfg_q.output_zero_point <= 8'd0;
		end else if (wr) begin
			case (idx)
				icmrq_pkg::REG_SCALE_MULT:  cfg_q.scale_multiplier  <= pwdata;
				icmrq_pkg::REG_SCALE_SHIFT: cfg_q.scale_shift       <= pwdata[5:0];
				icmrq_pkg::REG_CLAMP_LOW:   cfg_q.clamp_low         <= signed'(pwdata);
				icmrq_pkg::REG_CLAMP_HIGH:  cfg_q.clamp_high        <= signed'(pwdata);
				icmrq_pkg::REG_ZERO_POINT:  cfg_q.output_zero_point <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			icmrq_pkg::REG_SCALE_MULT:  prdata = cfg_q.scale_multiplier;
			icmrq_pkg::REG_SCALE_SHIFT: prdata = {26'd0, cfg_q.scale_shift};
			icmrq_pkg::REG_CLAMP_LOW:   prdata = cfg_q.clamp_low;
			icmrq_pkg::REG_CLAMP_HIGH:  prdata = cfg_q.clamp_high;
			icmrq_pkg::REG_ZERO_POINT:  prdata = {24'd0, cfg_q.output_zero_point};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> design/int8_conv_mac_requantize_16ch_unit.sv
// Usage:
//  item channel (item_valid/item_ready, payload item): func 0 loads the bias word of
//  one channel, func 1 multiplies (activation - 128) by each channel's int8 weight and
//  adds it to that channel's 32-bit wrapping accumulator. With last set, the block
//  requantizes all channels and clears the accumulators.
//  res channel (res_valid/res_ready, payload res): sixteen unsigned bytes per last MAC.
//  Config: APB-style, registers at byte addresses 0,4,8,12,16; pready always high.
//  Throughput: bias and non-last MAC transactions are taken one per cycle while no
//  result is in the requantize pipeline. A last MAC transaction occupies the per-lane
//  requantize pipeline (one 32x32 multiplier per lane, one result in flight): the result
//  passes stages s1 to s5 into the output register, with item_ready low until it leaves s5.
//  Stall: while res_ready is low the result waits in the output register and new
//  transactions are still taken; a second result waits in the last pipeline stage,
//  holding item_ready low until the output register drains.
//  Reset: accumulators and bias words clear to zero, registers take their defaults,
//  no result is pending.
// Depends on icmrq_pkg, icmrq_lane, icmrq_regs and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "int8_conv_mac_requantize_16ch_unit_defines.svh"

module int8_conv_mac_requantize_16ch_unit #(
	parameter int OUT_CHANNELS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire icmrq_pkg::item_t             item,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output icmrq_pkg::result_t                res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [icmrq_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int L = icmrq_pkg::LANES;
	localparam int NS = icmrq_pkg::NUM_STAGES;

	icmrq_pkg::cfg_t      cfg;
	icmrq_pkg::lane_ctl_t ctl;
	icmrq_pkg::result_t   res_q;
	logic [NS-1:0]        stage_vld_q;
	logic                 res_vld_q;
	logic                 item_acc;
	logic                 last_acc;
	logic                 move;
	logic [L*8-1:0]       weights_all;
	logic [L*8-1:0]       lane_bytes;

	icmrq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one last-MAC result in flight at a time
	assign item_ready = ~|stage_vld_q;
	assign item_acc   = item_valid && item_ready;
	assign last_acc   = item_acc && item.func && item.last;
	assign move       = stage_vld_q[NS-1] && (!res_vld_q || res_ready);

	assign ctl.mac  = item_acc && item.func;
	assign ctl.step = {stage_vld_q[NS-2:0], last_acc};

	// stage valid chain, last stage holds until the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= {stage_vld_q[NS-1] && !move, stage_vld_q[NS-3:0], last_acc}
				| {stage_vld_q[NS-2], {(NS-1){1'b0}}};
		end
	end

	// lanes
	assign weights_all = {item.weights_high, item.weights_low};

	for (genvar g = 0; g < L; g++) begin : g_lane
		if (g < OUT_CHANNELS) begin : g_on
			icmrq_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.cfg        (cfg),
				.bias_we    (item_acc && !item.func && (item.bias_index == 4'(g))),
				.bias_value (item.bias_value),
				.activation (item.activation),
				.weight     (weights_all[g*8 +: 8]),
				.res_byte   (lane_bytes[g*8 +: 8])
			);
		end else begin : g_off
			assign lane_bytes[g*8 +: 8] = 8'd0;
		end
	end

	// merge lane bytes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (move) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q.bytes_low  <= lane_bytes[63:0];
			res_q.bytes_high <= lane_bytes[L*8-1:64];
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	// checks
	`ICMRQ_ASSERT_NOW(a_one_in_flight, 1'b1, $onehot0(stage_vld_q), "more than one result in flight")
	`ICMRQ_ASSERT_NEXT(a_last_starts, last_acc, stage_vld_q[0] && !item_ready, "last MAC did not start requantize")
	`ICMRQ_ASSERT_NEXT(a_move_shows, move, res_valid, "moved result not presented")
	`ICMRQ_ASSERT_NEXT(a_hold_stalled, stage_vld_q[NS-1] && res_valid && !res_ready, stage_vld_q[NS-1], "stalled result lost")

endmodule

`default_nettype wire
